// ===== design/bfpa_pkg.sv =====
// Shared types for the best-fit partition allocator.
// Holds the scan token and the write bus that run between the top level and its cells.
// No dependencies.
package bfpa_pkg;

	// Widest partition index and widest size that the parameters allow.
	localparam int IDX_MAX_W  = 8;
	localparam int SIZE_MAX_W = 32;
	localparam int COUNT_W    = 5;

	// Scan token that walks the cell chain, one cell per cycle.
	typedef struct packed {
		logic                  active;
		logic                  found;
		logic [IDX_MAX_W-1:0]  idx;
		logic [SIZE_MAX_W-1:0] size;
	} tok_t;

	// Write bus into the cells: loads and request write-backs.
	typedef struct packed {
		logic                  en;
		logic [IDX_MAX_W-1:0]  idx;
		logic [SIZE_MAX_W-1:0] data;
	} wr_t;

endpackage

// ===== design/bfpa_cell.sv =====
// One partition cell of the best-fit allocator chain.
// Holds one free size and updates the passing scan token.
// Depends on bfpa_pkg.
module bfpa_cell #(
	parameter int IDX       = 0,
	parameter int SIZE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bfpa_pkg::COUNT_W-1:0] count,
	input  logic [SIZE_BITS-1:0]        req,
	input  bfpa_pkg::wr_t               wr,
	input  bfpa_pkg::tok_t              tok_in,
	output bfpa_pkg::tok_t              tok_out
);

	logic [SIZE_BITS-1:0] size_q;
	bfpa_pkg::tok_t       token_q;
	logic                 takes_part;
	logic                 better;

	// This cell joins the search only when it lies below the configured count.
	assign takes_part = 9'(IDX) < 9'(count);

	// A fitting cell wins if nothing was found yet or it is strictly smaller.
	assign better = takes_part && (size_q >= req) &&
		(!tok_in.found || (size_q < SIZE_BITS'(tok_in.size)));

	// The stored free size changes only through the write bus.
	always_ff @(posedge clk) begin
		if (wr.en && (wr.idx == bfpa_pkg::IDX_MAX_W'(IDX))) begin
			size_q <= SIZE_BITS'(wr.data);
		end
	end

	// Token register: the token moves one cell per clock and picks up this cell if it wins.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= '0;
		end else if (better) begin
			token_q.active <= tok_in.active;
			token_q.found  <= 1'b1;
			token_q.idx    <= bfpa_pkg::IDX_MAX_W'(IDX);
			token_q.size   <= bfpa_pkg::SIZE_MAX_W'(size_q);
		end else begin
			token_q <= tok_in;
		end
	end

	assign tok_out = token_q;

endmodule

// ===== design/best_fit_partition_allocator.sv =====
// Best-fit partition allocator: a chain of PARTITIONS cells, each holding one free size.
// A load (op 0) writes one cell and presents its result in the next cycle. A request (op 1)
// sends a token down the chain, one cell per cycle, that keeps the smallest fitting size
// (lowest index on ties); after the last cell the chosen entry is written back and its result
// registered, held while out_valid is high and out_ready is low. One item is in flight at a
// time. The free sizes are undefined until loaded. The user must write the blocks_in_use
// register (reset 16) through the cfg channel only while the block is idle; the block itself
// does not enforce this.
// Depends on bfpa_pkg and bfpa_cell.
module best_fit_partition_allocator #(
	parameter int PARTITIONS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [3:0]  slot,
	input  logic [15:0] size,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        granted,
	output logic [3:0]  block_index,
	output logic [15:0] remaining,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_WB   = 2'd2;

	logic [1:0]                          state_q;
	logic                                start_q;
	logic                                out_valid_q;
	logic [bfpa_pkg::COUNT_W-1:0]        biu_q;
	logic [SIZE_BITS-1:0]                req_q;
	logic                                res_found_q;
	logic [bfpa_pkg::IDX_MAX_W-1:0]      res_idx_q;
	logic [SIZE_BITS-1:0]                res_size_q;
	logic                                granted_q;
	logic [3:0]                          index_q;
	logic [15:0]                         rem_q;

	logic                                in_acc;
	logic                                load_acc;
	logic                                req_acc;
	logic                                slot_ok;
	logic                                wb_go;
	logic [SIZE_BITS-1:0]                load_size;
	logic [SIZE_BITS-1:0]                left_size;
	bfpa_pkg::wr_t                       wr;
	bfpa_pkg::tok_t                      chain [PARTITIONS+1];
	logic [PARTITIONS-1:0]               act;
	logic                                scan_done;

	// Handshakes and decoded transactions.
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_acc    = in_valid && in_ready;
	assign load_acc  = in_acc && !op;
	assign req_acc   = in_acc && op;
	assign cfg_ready = 1'b1;
	assign slot_ok   = {5'd0, slot} < 9'(PARTITIONS);
	assign load_size = SIZE_BITS'(size);
	assign left_size = res_size_q - req_q;
	assign wb_go     = (state_q == ST_WB) && (!out_valid_q || out_ready);
	assign scan_done = chain[PARTITIONS].active;

	// Write bus: a load writes its slot, a granted request writes back the remainder.
	always_comb begin
		wr = '0;
		if (load_acc) begin
			wr.en   = slot_ok;
			wr.idx  = bfpa_pkg::IDX_MAX_W'(slot);
			wr.data = bfpa_pkg::SIZE_MAX_W'(load_size);
		end else if (wb_go) begin
			wr.en   = res_found_q;
			wr.idx  = res_idx_q;
			wr.data = bfpa_pkg::SIZE_MAX_W'(left_size);
		end
	end

	// A fresh token enters the first cell in the cycle after a request is accepted.
	always_comb begin
		chain[0]        = '0;
		chain[0].active = start_q;
	end

	// The cell chain.
	for (genvar g = 0; g < PARTITIONS; g++) begin : g_cell
		bfpa_cell #(
			.IDX       (g),
			.SIZE_BITS (SIZE_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.count   (biu_q),
			.req     (req_q),
			.wr      (wr),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
		assign act[g] = chain[g+1].active;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			biu_q       <= 5'd16;
		end else begin
			start_q <= req_acc;
			if (cfg_valid && cfg_ready) begin
				biu_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (wb_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_acc || wb_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request, scan result and output payload registers.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_q <= load_size;
		end
		if ((state_q == ST_SCAN) && scan_done) begin
			res_found_q <= chain[PARTITIONS].found;
			res_idx_q   <= chain[PARTITIONS].idx;
			res_size_q  <= SIZE_BITS'(chain[PARTITIONS].size);
		end
		if (load_acc) begin
			granted_q <= 1'b0;
			index_q   <= slot;
			rem_q     <= slot_ok ? 16'(load_size) : 16'd0;
		end else if (wb_go) begin
			granted_q <= res_found_q;
			index_q   <= res_found_q ? 4'(res_idx_q) : 4'd0;
			rem_q     <= res_found_q ? 16'(left_size) : 16'd0;
		end
	end

	assign out_valid   = out_valid_q;
	assign granted     = granted_q;
	assign block_index = index_q;
	assign remaining   = rem_q;

	// At most one token travels the chain at a time.
	assert property (@(posedge clk) disable iff (!arst_n) $countones(act) <= 1)
		else $error("more than one scan token in the chain");

	// A token leaves the last cell only while a scan is under way.
	assert property (@(posedge clk) disable iff (!arst_n) scan_done |-> state_q == ST_SCAN)
		else $error("scan token finished outside a scan");

	// A chosen partition always lies inside the configured count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) && res_found_q |-> {1'b0, res_idx_q} < 9'(biu_q))
		else $error("chosen partition outside the configured count");

	// A request's result appears only through the write-back step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && granted_q |-> $past(state_q) == ST_WB)
		else $error("grant presented without a write-back");

endmodule

// ===== tb/best_fit_partition_allocator_test.sv =====
// Self-checking testbench for the best-fit partition allocator.
// A scoreboard class predicts every grant from its own copy of the partition table.
// Depends only on best_fit_partition_allocator and its package.
`timescale 1ns / 100ps

module best_fit_partition_allocator_test;

	localparam int PARTS        = 16;
	localparam int RANDOM_ITEMS = 1800;
	localparam int CALM_ITEMS   = 200;
	localparam int PHASE_LEN    = 150;
	localparam int MAX_REPORTS  = 60;

	// Operation codes carried on the op port.
	localparam bit OP_LOAD    = 1'b0;
	localparam bit OP_REQUEST = 1'b1;

	// One expected result transaction.
	typedef struct {
		bit        granted;
		bit [3:0]  block;
		bit [15:0] rem;
	} grant_t;

	// Predicts results from accepted inputs and checks them in order.
	class alloc_scoreboard;
		bit [15:0]   free_tab [PARTS];
		bit [4:0]    num_parts;
		grant_t      expected_q [$];
		int unsigned errors;

		function new();
			foreach (free_tab[i])
				free_tab[i] = '0;
			num_parts = 5'd16;
			errors    = 0;
		endfunction

		function void set_count(bit [4:0] v);
			num_parts = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Work out the result of one accepted input transaction.
		function void note_input(bit o, bit [3:0] s, bit [15:0] sz);
			grant_t r;
			int     lim;
			int     best;
			bit     found;
			r     = '{1'b0, 4'd0, 16'd0};
			found = 1'b0;
			best  = 0;
			if (o == OP_LOAD) begin
				free_tab[s] = sz;
				r.block     = s;
				r.rem       = sz;
			end else begin
				lim = (num_parts > PARTS) ? PARTS : num_parts;
				// Smallest fitting size wins; the strict compare keeps the lowest index on ties.
				for (int j = 0; j < lim; j++) begin
					if (free_tab[j] >= sz && (!found || free_tab[j] < free_tab[best])) begin
						best  = j;
						found = 1'b1;
					end
				end
				if (found) begin
					free_tab[best] = free_tab[best] - sz;
					r.granted      = 1'b1;
					r.block        = best[3:0];
					r.rem          = free_tab[best];
				end
			end
			expected_q.push_back(r);
		endfunction

		function void flag(string name, int exp_v, logic [15:0] act_v);
			errors++;
			// Keep the log readable once things go badly wrong.
			if (errors <= MAX_REPORTS)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
					act_v);
		endfunction

		// Compare one accepted result transaction with the oldest expectation.
		function void check_result(logic g, logic [3:0] b, logic [15:0] rem);
			grant_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t ns: unexpected result, expected none, actual %0b/%0d/%0d",
						$time, g, b, rem);
				return;
			end
			e = expected_q.pop_front();
			if (g !== e.granted)
				flag("granted", e.granted, {15'd0, g});
			if (b !== e.block)
				flag("block_index", e.block, {12'd0, b});
			if (rem !== e.rem)
				flag("remaining", e.rem, rem);
		endfunction
	endclass

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic        op          = 1'b0;
	logic [3:0]  slot        = '0;
	logic [15:0] size        = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic        granted;
	logic [3:0]  block_index;
	logic [15:0] remaining;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic [4:0]  cfg_data    = '0;

	bit              calm = 1'b0;
	alloc_scoreboard sb   = new();

	best_fit_partition_allocator u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.slot        (slot),
		.size        (size),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.granted     (granted),
		.block_index (block_index),
		.remaining   (remaining),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	// Result side: random stall bursts, always ready during the calm tail.
	initial begin
		@(posedge clk);
		forever begin
			if (calm) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Check every result transaction taken at a clock edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(granted, block_index, remaining);
	end

	// Present one input transaction, possibly after a short gap, and hold it until taken.
	task automatic send_item(input bit o, input bit [3:0] s, input bit [15:0] sz);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		slot     <= s;
		size     <= sz;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_input(o, s, sz);
	endtask

	// Write blocks_in_use once every outstanding result has come back.
	task automatic write_count(input bit [4:0] v);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_count(v);
		// Let the valid drop take effect before anything else is driven.
		@(posedge clk);
	endtask

	function automatic bit [4:0] pick_count();
		case ($urandom_range(0, 5))
			0: return 5'd1;
			1: return 5'd16;
			2: return 5'd0;
			3: return 5'd31;
			4: return 5'($urandom_range(17, 31));
			default: return 5'($urandom_range(1, 16));
		endcase
	endfunction

	// Load sizes: wide values, small ones, copies of other entries for ties, extremes.
	function automatic bit [15:0] pick_load_size();
		case ($urandom_range(0, 4))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'($urandom_range(0, 255));
			2: return sb.free_tab[$urandom_range(0, PARTS - 1)];
			3: return ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
			default: return 16'($urandom_range(256, 4095));
		endcase
	endfunction

	// Request sizes are mostly drawn from the table so that grants, exact fits and
	// near misses all happen often.
	function automatic bit [15:0] pick_request_size();
		bit [15:0] t;
		t = sb.free_tab[$urandom_range(0, PARTS - 1)];
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 65535));
			1: return 16'($urandom_range(0, 15));
			2: return t;
			3: return 16'($urandom_range(0, t));
			4: return t + 16'd1;
			default: return ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
		endcase
	endfunction

	// Main sequence: reset, directed cases, then random phases with varying counts.
	initial begin
		bit [15:0] seed [PARTS];
		seed = '{16'd100, 16'hFFFF, 16'd50, 16'd50, 16'd0, 16'd200, 16'd300, 16'd1000,
			16'd5000, 16'd50, 16'd7, 16'd8, 16'd9000, 16'd12345, 16'd40000, 16'd65534};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every entry is loaded before the first request, so no request reads an unset one.
		for (int i = 0; i < PARTS; i++)
			send_item(OP_LOAD, 4'(i), seed[i]);
		// Ties on 50, then a zero-size request, then the full-width request and a miss.
		send_item(OP_REQUEST, 4'd0, 16'd50);
		send_item(OP_REQUEST, 4'd15, 16'd50);
		send_item(OP_REQUEST, 4'd0, 16'd0);
		send_item(OP_REQUEST, 4'd0, 16'hFFFF);
		send_item(OP_REQUEST, 4'd0, 16'hFFFF);
		// No partition takes part, so the request misses.
		write_count(5'd0);
		send_item(OP_REQUEST, 4'd0, 16'd0);
		// A count beyond the table searches the whole table.
		write_count(5'd31);
		send_item(OP_REQUEST, 4'd0, 16'd40000);
		// Only partition 0 takes part.
		write_count(5'd1);
		send_item(OP_REQUEST, 4'd3, 16'd200);
		send_item(OP_REQUEST, 4'd9, 16'd100);
		write_count(5'd16);

		// Random phases: loads refill the table, requests drain it.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % PHASE_LEN == 0)
				write_count(pick_count());
			if (n == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			if ($urandom_range(0, 9) < 4)
				send_item(OP_LOAD, 4'($urandom_range(0, 15)), pick_load_size());
			else
				send_item(OP_REQUEST, 4'($urandom_range(0, 15)), pick_request_size());
		end
		in_valid <= 1'b0;

		// Drain, then watch a little longer for stray results.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (PARTS + 8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Hard stop if the block hangs.
	initial begin
		#3000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/bfpa_pkg.sv
design/bfpa_cell.sv
design/best_fit_partition_allocator.sv
tb/best_fit_partition_allocator_test.sv
